>>> hdl/dhmt_pkg.sv
// shared types and constants for the double hashed key/value table
// no dependencies

package dhmt_pkg;

  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned VAL_W      = 24;
  localparam int unsigned RES_W      = 3;

  localparam int unsigned MIN_LOG2   = 2;
  localparam int unsigned SIZE_RESET = 8;

  // load limit: full when live plus tombstones reaches num/den of slots
  localparam int unsigned LOAD_NUM   = 3;
  localparam int unsigned LOAD_DEN   = 4;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_state_e;

  typedef enum logic [RES_W-1:0] {
    RES_ADDED    = 3'd0,
    RES_DUP      = 3'd1,
    RES_FOUND    = 3'd2,
    RES_NOTFOUND = 3'd3,
    RES_REMOVED  = 3'd4,
    RES_FULL     = 3'd5
  } result_e;

  typedef struct packed {
    logic        rd_en;
    logic        st_we;
    logic        dt_we;
    slot_state_e st_wdata;
  } slot_ctl_t;

endpackage

>>> hdl/dhmt_step_mix.sv
// probe step generator: shift, add and xor mix of the key hash, forced odd
// depends on dhmt_pkg

module dhmt_step_mix #(
  parameter int unsigned IDX_W = 8
) (
  input  logic                        clk_i,
  input  logic                        ld_i,
  input  logic [dhmt_pkg::HASH_W-1:0] hash_i,
  output logic [IDX_W-1:0]            jump_o
);
  import dhmt_pkg::*;

  localparam int unsigned SH_A = 23;
  localparam int unsigned SH_B = 12;
  localparam int unsigned SH_C = 7;
  localparam int unsigned SH_D = 2;
  localparam int unsigned SH_E = 20;

  logic [HASH_W-1:0] h1, h2, h3, h4, h5;
  logic [IDX_W-1:0]  jump_q;

  always_comb begin
    h1 = ~hash_i + (hash_i >> SH_A);
    h2 = h1 ^ (h1 << SH_B);
    h3 = h2 ^ (h2 >> SH_C);
    h4 = h3 ^ (h3 << SH_D);
    h5 = h4 ^ (h4 >> SH_E);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      jump_q <= h5[IDX_W-1:0] | IDX_W'(1);
    end
  end

  assign jump_o = jump_q;

endmodule

>>> hdl/dhmt_slot_store.sv
// slot storage: state memory and key/tag/value memory, registered reads
// depends on dhmt_pkg

module dhmt_slot_store #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned VALUE_BITS = 24
) (
  input  logic                        clk_i,
  input  dhmt_pkg::slot_ctl_t         ctl_i,
  input  logic [$clog2(SLOTS)-1:0]    addr_i,
  input  logic [dhmt_pkg::KEY_W-1:0]  wr_key_i,
  input  logic [dhmt_pkg::TAG_W-1:0]  wr_tag_i,
  input  logic [VALUE_BITS-1:0]       wr_val_i,
  output dhmt_pkg::slot_state_e       rd_state_o,
  output logic [dhmt_pkg::KEY_W-1:0]  rd_key_o,
  output logic [dhmt_pkg::TAG_W-1:0]  rd_tag_o,
  output logic [VALUE_BITS-1:0]       rd_val_o
);
  import dhmt_pkg::*;

  localparam int unsigned ENT_W = KEY_W + TAG_W + VALUE_BITS;

  slot_state_e      st_mem [SLOTS];
  logic [ENT_W-1:0] dt_mem [SLOTS];

  slot_state_e      rd_state_q;
  logic [ENT_W-1:0] rd_ent_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.st_we) begin
      st_mem[addr_i] <= ctl_i.st_wdata;
    end
    if (ctl_i.rd_en) begin
      rd_state_q <= st_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.dt_we) begin
      dt_mem[addr_i] <= {wr_key_i, wr_tag_i, wr_val_i};
    end
    if (ctl_i.rd_en) begin
      rd_ent_q <= dt_mem[addr_i];
    end
  end

  assign rd_state_o = rd_state_q;
  assign rd_key_o   = rd_ent_q[ENT_W-1 -: KEY_W];
  assign rd_tag_o   = rd_ent_q[VALUE_BITS +: TAG_W];
  assign rd_val_o   = rd_ent_q[VALUE_BITS-1:0];

endmodule

>>> hdl/double_hash_map_with_tombstones_top.sv
// Open addressed key/value table with double hashing and tombstones. After reset the
// block sweeps the slot state memory, marking each slot empty, and holds in_stall_o high
// meanwhile; size writes are taken at any time. An item is then accepted, probed one
// slot at a time and answered: each probe is one slot memory read followed by one
// compare, the probe position advancing through the probe adder, and a finish step then
// updates the slot and sets the result; an item takes from 1 to as many probes as there
// are slots in use, and an unused operation code is answered without any probe. The next
// item is accepted in the cycle after its result is taken.
// depends on dhmt_pkg, dhmt_step_mix, dhmt_slot_store

module double_hash_map_with_tombstones_top #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned VALUE_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dhmt_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dhmt_pkg::OP_W-1:0]   operation_i,
  input  logic [dhmt_pkg::KEY_W-1:0]  key_id_i,
  input  logic [dhmt_pkg::HASH_W-1:0] key_hash_i,
  input  logic [dhmt_pkg::TAG_W-1:0]  tag_i,
  input  logic [dhmt_pkg::VAL_W-1:0]  value_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dhmt_pkg::RES_W-1:0]  status_o,
  output logic [dhmt_pkg::VAL_W-1:0]  value_out_o
);
  import dhmt_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned SUM_W = IDX_W + 4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH,
    S_OUT
  } state_e;

  function automatic logic [IDX_W:0] slots_used(logic [SIZE_W-1:0] lg_raw);
    logic [SIZE_W-1:0] lg;
    lg = (lg_raw < SIZE_W'(MIN_LOG2)) ? SIZE_W'(MIN_LOG2) : lg_raw;
    if (int'(lg) >= IDX_W) begin
      return (IDX_W+1)'(SLOTS);
    end
    return (IDX_W+1)'(1) << lg;
  endfunction

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [CNT_W-1:0]  live_q, live_d;
  logic [CNT_W-1:0]  tomb_q, tomb_d;
  result_e           status_q, status_d;
  logic [VAL_W-1:0]  vout_q, vout_d;

  logic [OP_W-1:0]       op_q, op_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [TAG_W-1:0]      tag_q, tag_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [IDX_W-1:0]      mask_q, mask_d;
  logic [IDX_W:0]        n_q, n_d;
  logic [IDX_W:0]        probes_q, probes_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  logic [IDX_W-1:0]      cand_q, cand_d;
  logic                  have_cand_q, have_cand_d;
  logic                  hit_empty_q, hit_empty_d;
  logic                  matched_q, matched_d;

  slot_ctl_t             ctl;
  logic [IDX_W-1:0]      mem_addr;
  logic [IDX_W-1:0]      jump;
  slot_state_e           rd_state;
  logic [KEY_W-1:0]      rd_key;
  logic [TAG_W-1:0]      rd_tag;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  accept;
  logic                  load_ok;

  assign accept = in_valid_i && (state_q == S_IDLE);

  dhmt_step_mix #(
    .IDX_W (IDX_W)
  ) u_step_mix (
    .clk_i  (clk_i),
    .ld_i   (accept),
    .hash_i (key_hash_i),
    .jump_o (jump)
  );

  dhmt_slot_store #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_slot_store (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .addr_i     (mem_addr),
    .wr_key_i   (key_q),
    .wr_tag_i   (tag_q),
    .wr_val_i   (val_q),
    .rd_state_o (rd_state),
    .rd_key_o   (rd_key),
    .rd_tag_o   (rd_tag),
    .rd_val_o   (rd_val)
  );

  assign load_ok = ((SUM_W'(live_q) + SUM_W'(tomb_q)) * SUM_W'(LOAD_DEN))
                   < (SUM_W'(n_q) * SUM_W'(LOAD_NUM));

  always_comb begin
    logic advance;
    advance     = 1'b0;
    state_d     = state_q;
    clr_d       = clr_q;
    size_d      = cfg_we_i ? cfg_wdata_i : size_q;
    live_d      = live_q;
    tomb_d      = tomb_q;
    status_d    = status_q;
    vout_d      = vout_q;
    op_d        = op_q;
    key_d       = key_q;
    tag_d       = tag_q;
    val_d       = val_q;
    pos_d       = pos_q;
    mask_d      = mask_q;
    n_d         = n_q;
    probes_d    = probes_q;
    slot_d      = slot_q;
    cand_d      = cand_q;
    have_cand_d = have_cand_q;
    hit_empty_d = hit_empty_q;
    matched_d   = matched_q;
    ctl         = '0;
    mem_addr    = pos_q & mask_q;

    unique case (state_q)
      S_CLEAR: begin
        ctl.st_we    = 1'b1;
        ctl.st_wdata = ST_EMPTY;
        mem_addr     = clr_q;
        clr_d        = clr_q + IDX_W'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d        = operation_i;
          key_d       = key_id_i;
          tag_d       = tag_i;
          val_d       = value_in_i[VALUE_BITS-1:0];
          pos_d       = key_hash_i[IDX_W-1:0];
          n_d         = slots_used(size_q);
          mask_d      = IDX_W'(slots_used(size_q) - (IDX_W+1)'(1));
          probes_d    = '0;
          have_cand_d = 1'b0;
          hit_empty_d = 1'b0;
          matched_d   = 1'b0;
          if (operation_i == OP_ADD || operation_i == OP_FIND ||
              operation_i == OP_REMOVE) begin
            state_d = S_READ;
          end else begin
            status_d = RES_NOTFOUND;
            vout_d   = '0;
            state_d  = S_OUT;
          end
        end
      end
      S_READ: begin
        ctl.rd_en = 1'b1;
        slot_d    = pos_q & mask_q;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        priority if (rd_state == ST_EMPTY) begin
          hit_empty_d = 1'b1;
          state_d     = S_FINISH;
        end else if (rd_state == ST_TOMB) begin
          if (!have_cand_q) begin
            have_cand_d = 1'b1;
            cand_d      = slot_q;
          end
          advance = 1'b1;
        end else if (rd_state == ST_LIVE && rd_key == key_q && rd_tag == tag_q) begin
          matched_d = 1'b1;
          state_d   = S_FINISH;
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          pos_d    = pos_q + jump;
          probes_d = probes_q + (IDX_W+1)'(1);
          state_d  = (probes_q + (IDX_W+1)'(1) == n_q) ? S_FINISH : S_READ;
        end
      end
      S_FINISH: begin
        vout_d   = '0;
        status_d = RES_NOTFOUND;
        unique case (op_q)
          OP_ADD: begin
            if (matched_q) begin
              status_d = RES_DUP;
            end else if (have_cand_q || (hit_empty_q && load_ok)) begin
              mem_addr     = have_cand_q ? cand_q : slot_q;
              ctl.st_we    = 1'b1;
              ctl.dt_we    = 1'b1;
              ctl.st_wdata = ST_LIVE;
              live_d       = live_q + CNT_W'(1);
              if (have_cand_q && tomb_q != '0) begin
                tomb_d = tomb_q - CNT_W'(1);
              end
              status_d = RES_ADDED;
            end else begin
              status_d = RES_FULL;
            end
          end
          OP_FIND: begin
            if (matched_q) begin
              status_d = RES_FOUND;
              vout_d   = VAL_W'(rd_val);
            end
          end
          OP_REMOVE: begin
            if (matched_q) begin
              mem_addr     = slot_q;
              ctl.st_we    = 1'b1;
              ctl.st_wdata = ST_TOMB;
              if (live_q != '0) begin
                live_d = live_q - CNT_W'(1);
              end
              tomb_d   = tomb_q + CNT_W'(1);
              status_d = RES_REMOVED;
              vout_d   = VAL_W'(rd_val);
            end
          end
          default: begin
            status_d = RES_NOTFOUND;
          end
        endcase
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      size_q   <= SIZE_W'(SIZE_RESET);
      live_q   <= '0;
      tomb_q   <= '0;
      status_q <= RES_NOTFOUND;
      vout_q   <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      size_q   <= size_d;
      live_q   <= live_d;
      tomb_q   <= tomb_d;
      status_q <= status_d;
      vout_q   <= vout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    tag_q       <= tag_d;
    val_q       <= val_d;
    pos_q       <= pos_d;
    mask_q      <= mask_d;
    n_q         <= n_d;
    probes_q    <= probes_d;
    slot_q      <= slot_d;
    cand_q      <= cand_d;
    have_cand_q <= have_cand_d;
    hit_empty_q <= hit_empty_d;
    matched_q   <= matched_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = status_q;
  assign value_out_o = vout_q;

  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("not busy after an item was accepted");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SUM_W'(live_q) + SUM_W'(tomb_q)) <= SUM_W'(SLOTS))
    else $error("live and tombstone counts exceed the slot count");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != RES_FOUND && status_o != RES_REMOVED)
      |-> (value_out_o == '0))
    else $error("value returned without a found or removed entry");

  a_check_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> ($past(state_q) == S_READ))
    else $error("compare without a preceding slot read");

endmodule

>>> dv/tb_double_hash_map_with_tombstones_top.sv
// Self-checking testbench for double_hash_map_with_tombstones_top: a directed table walk,
// then random add/find/remove traffic, with some unused codes, over several table sizes,
// checked against a behavioural table model. Depends on dhmt_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_double_hash_map_with_tombstones_top;
  import dhmt_pkg::*;

  localparam int unsigned SLOTS         = 256;
  localparam int unsigned VALUE_BITS    = 24;
  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned POOL_N        = 320;
  localparam int unsigned NUM_PHASES    = 9;
  localparam int unsigned PHASE_ITEMS   = 167;
  localparam int unsigned HOLD_AT       = 500;
  localparam int unsigned HOLD_LEN      = 300;
  localparam int unsigned DRAIN_CYCLES  = 2 * SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT   = 4000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // table sizes per random phase, phase 0 in the low nibble
  localparam logic [NUM_PHASES*SIZE_W-1:0] PHASE_SIZES =
    {4'd3, 4'd8, 4'd9, 4'd2, 4'd7, 4'd15, 4'd6, 4'd5, 4'd4};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic [TAG_W-1:0]  tag;
    logic [VAL_W-1:0]  val;
  } table_req_t;

  typedef struct packed {
    result_e          status;
    logic [VAL_W-1:0] value;
  } table_rsp_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [SIZE_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i = '0;
  logic [KEY_W-1:0]    key_id_i    = '0;
  logic [HASH_W-1:0]   key_hash_i  = '0;
  logic [TAG_W-1:0]    tag_i       = '0;
  logic [VAL_W-1:0]    value_in_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b1;
  logic [RES_W-1:0]    status_o;
  logic [VAL_W-1:0]    value_out_o;

  table_req_t  req_pending[$];
  table_rsp_t  rsp_expected[$];

  slot_state_e       tbl_state [SLOTS];
  logic [KEY_W-1:0]  tbl_key   [SLOTS];
  logic [TAG_W-1:0]  tbl_tag   [SLOTS];
  logic [VAL_W-1:0]  tbl_value [SLOTS];
  int unsigned       live_cnt  = 0;
  int unsigned       tomb_cnt  = 0;
  logic [SIZE_W-1:0] size_lg   = SIZE_RESET[SIZE_W-1:0];

  logic [KEY_W-1:0]  pool_key  [POOL_N];
  logic [HASH_W-1:0] pool_hash [POOL_N];
  logic [TAG_W-1:0]  pool_tag  [POOL_N];

  logic        in_taken      = 1'b0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 71;
  int unsigned rsp_seen      = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned err_cnt       = 0;
  int unsigned size_cfgs     = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned status_hist [6];

  double_hash_map_with_tombstones_top #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .key_id_i    (key_id_i),
    .key_hash_i  (key_hash_i),
    .tag_i       (tag_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_out_o (value_out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic table_rsp_t apply_request(table_req_t rq);
    int unsigned lg, n, probes, s, cand;
    logic [31:0] pos, stride, mask;
    bit          have_cand, hit_empty, matched, ok;
    table_rsp_t  rsp;
    rsp.status = RES_NOTFOUND;
    rsp.value  = '0;
    if (rq.op == OP_UNUSED) return rsp;
    lg = size_lg;
    if (lg < MIN_LOG2) lg = MIN_LOG2;
    n = 1 << lg;
    if (n > SLOTS) n = SLOTS;
    mask = n - 1;
    stride = ~rq.hash + (rq.hash >> 23);
    stride ^= stride << 12;
    stride ^= stride >> 7;
    stride ^= stride << 2;
    stride ^= stride >> 20;
    stride |= 32'd1;
    pos = rq.hash;
    have_cand = 1'b0;
    hit_empty = 1'b0;
    cand = 0;
    s = 0;
    for (probes = 0; probes < n; probes++) begin
      s = pos & mask;
      if (tbl_state[s] == ST_EMPTY) begin
        hit_empty = 1'b1;
        break;
      end
      if (tbl_state[s] == ST_TOMB) begin
        if (!have_cand) begin
          have_cand = 1'b1;
          cand = s;
        end
      end else if (tbl_key[s] == rq.key && tbl_tag[s] == rq.tag) begin
        break;
      end
      pos += stride;
    end
    matched = (probes < n) && !hit_empty;
    if (rq.op == OP_ADD) begin
      if (matched) begin
        rsp.status = RES_DUP;
      end else begin
        ok = 1'b0;
        if (have_cand) begin
          s = cand;
          ok = 1'b1;
          if (tomb_cnt > 0) tomb_cnt--;
        end else if (hit_empty && LOAD_DEN * (live_cnt + tomb_cnt) < LOAD_NUM * n) begin
          ok = 1'b1;
        end
        if (ok) begin
          tbl_state[s] = ST_LIVE;
          tbl_key[s]   = rq.key;
          tbl_tag[s]   = rq.tag;
          tbl_value[s] = rq.val & VAL_W'((1 << VALUE_BITS) - 1);
          live_cnt++;
          rsp.status = RES_ADDED;
        end else begin
          rsp.status = RES_FULL;
        end
      end
    end else if (matched) begin
      rsp.value = tbl_value[s];
      if (rq.op == OP_FIND) begin
        rsp.status = RES_FOUND;
      end else begin
        tbl_state[s] = ST_TOMB;
        if (live_cnt > 0) live_cnt--;
        tomb_cnt++;
        rsp.status = RES_REMOVED;
      end
    end
    return rsp;
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [HASH_W-1:0] hash, input logic [TAG_W-1:0] tag,
                               input logic [VAL_W-1:0] val);
    table_req_t rq;
    rq = {op, key, hash, tag, val};
    req_pending.push_back(rq);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (req_pending.size() != 0 || in_valid_i || rsp_expected.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_table_size(input logic [SIZE_W-1:0] lg);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lg;
    size_lg = lg;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    size_cfgs++;
  endtask

  // sender
  always @(negedge clk_i) begin : drive_requests
    table_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (req_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        nxt = req_pending.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= nxt.op;
        key_id_i    <= nxt.key;
        key_hash_i  <= nxt.hash;
        tag_i       <= nxt.tag;
        value_in_i  <= nxt.val;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && rsp_seen >= HOLD_AT) begin
      hold_left   <= HOLD_LEN;
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    table_rsp_t want;
    table_req_t seen;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        rsp_seen++;
        if (rsp_expected.size() == 0) begin
          $error("result with no item outstanding: status %0d value_out %0h",
                 status_o, value_out_o);
          err_cnt++;
        end else begin
          want = rsp_expected.pop_front();
          status_hist[want.status]++;
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            err_cnt++;
          end
          if (value_out_o !== want.value) begin
            $error("value_out: expected %0h, actual %0h", want.value, value_out_o);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        seen = {operation_i, key_id_i, key_hash_i, tag_i, value_in_i};
        rsp_expected.push_back(apply_request(seen));
      end
      in_taken <= in_valid_i && !in_stall_o;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : run_sequence
    int unsigned       lg, pool_n, idx, r;
    logic [31:0]       rnd_a, rnd_b, rnd_c, rnd_v;
    logic [OP_W-1:0]   op;
    for (int i = 0; i < SLOTS; i++) tbl_state[i] = ST_EMPTY;
    for (int i = 0; i < 6; i++) status_hist[i] = 0;
    for (int i = 0; i < POOL_N; i++) begin
      rnd_a = $urandom;
      rnd_b = $urandom;
      rnd_c = $urandom;
      pool_key[i]  = rnd_a;
      pool_hash[i] = rnd_b;
      pool_tag[i]  = rnd_c[TAG_W-1:0];
      if (i > 0 && $urandom_range(3, 0) == 0) pool_hash[i] = pool_hash[$urandom_range(i - 1, 0)];
      if (i > 0 && $urandom_range(4, 0) == 0) pool_key[i] = pool_key[$urandom_range(i - 1, 0)];
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // four slots: duplicates, tags, full table, tombstone reuse, unused code
    set_table_size(4'd0);
    queue_request(OP_FIND,   32'h0, 32'h0, 8'h00, 24'h0);
    queue_request(OP_REMOVE, 32'h0, 32'h0, 8'h00, 24'hFFFFFF);
    queue_request(OP_ADD,    32'h0, 32'h0, 8'h00, 24'h0);
    queue_request(OP_ADD,    32'h0, 32'h0, 8'h00, 24'h1);
    queue_request(OP_ADD,    32'h0, 32'h0, 8'hFF, 24'hFFFFFF);
    queue_request(OP_FIND,   32'h0, 32'h0, 8'h00, 24'h0);
    queue_request(OP_FIND,   32'h0, 32'h0, 8'hFF, 24'h0);
    queue_request(OP_ADD,    32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 24'hFFFFFF);
    queue_request(OP_ADD,    32'h5, 32'h2, 8'h01, 24'h00ABCD);
    queue_request(OP_REMOVE, 32'h0, 32'h0, 8'h00, 24'h0);
    queue_request(OP_FIND,   32'h0, 32'h0, 8'h00, 24'h0);
    queue_request(OP_ADD,    32'h5, 32'h2, 8'h01, 24'h0ABCDE);
    queue_request(OP_UNUSED, 32'h5, 32'h2, 8'h01, 24'hFFFFFF);
    queue_request(OP_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 24'h0);
    queue_request(OP_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 24'h0);
    // grow, fill the low slots, then shrink so the probe finds no empty slot
    set_table_size(4'd3);
    queue_request(OP_ADD,    32'h10, 32'h2, 8'h10, 24'h123456);
    queue_request(OP_ADD,    32'h11, 32'h4, 8'h11, 24'h654321);
    queue_request(OP_ADD,    32'h12, 32'h5, 8'h12, 24'h0F0F0F);
    queue_request(OP_ADD,    32'h13, 32'h6, 8'h13, 24'hF0F0F0);
    set_table_size(4'd1);
    queue_request(OP_FIND,   32'h99, 32'h0, 8'h00, 24'h0);
    queue_request(OP_REMOVE, 32'h99, 32'h0, 8'h00, 24'h0);
    queue_request(OP_ADD,    32'h99, 32'h0, 8'h00, 24'h555555);
    queue_request(OP_ADD,    32'h9A, 32'h1, 8'h00, 24'hAAAAAA);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_table_size(PHASE_SIZES[ph*SIZE_W +: SIZE_W]);
      if (ph < 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 71;
      end else if (ph < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      lg = PHASE_SIZES[ph*SIZE_W +: SIZE_W];
      if (lg < MIN_LOG2) lg = MIN_LOG2;
      if (lg > 8) lg = 8;
      pool_n = (1 << lg) + (1 << lg) / 4;
      if (pool_n > POOL_N) pool_n = POOL_N;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r     = $urandom_range(99, 0);
        idx   = $urandom_range(pool_n - 1, 0);
        rnd_a = $urandom;
        rnd_b = $urandom;
        rnd_c = $urandom;
        rnd_v = $urandom;
        if (r < 45) begin
          queue_request(OP_ADD, pool_key[idx], pool_hash[idx], pool_tag[idx], rnd_v[VAL_W-1:0]);
        end else if (r < 72) begin
          queue_request(OP_FIND, pool_key[idx], pool_hash[idx], pool_tag[idx], rnd_v[VAL_W-1:0]);
        end else if (r < 92) begin
          queue_request(OP_REMOVE, pool_key[idx], pool_hash[idx], pool_tag[idx],
                        rnd_v[VAL_W-1:0]);
        end else if (r < 94) begin
          queue_request(OP_UNUSED, rnd_a, pool_hash[idx], rnd_c[TAG_W-1:0], rnd_v[VAL_W-1:0]);
        end else if (r < 97) begin
          op = OP_W'($urandom_range(2, 0));
          queue_request(op, rnd_a, rnd_b, rnd_c[TAG_W-1:0], rnd_v[VAL_W-1:0]);
        end else begin
          // known key with a wrong tag or a stray hash
          op = OP_W'($urandom_range(2, 0));
          if (rnd_c[31])
            queue_request(op, pool_key[idx], pool_hash[idx], pool_tag[idx] ^ rnd_c[TAG_W-1:0],
                          rnd_v[VAL_W-1:0]);
          else
            queue_request(op, pool_key[idx], rnd_b, pool_tag[idx], rnd_v[VAL_W-1:0]);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("checked %0d results over %0d size settings, long output hold-off included",
             rsp_seen, size_cfgs);
    $display("added %0d, duplicate %0d, found %0d, not found %0d, removed %0d, full %0d",
             status_hist[RES_ADDED], status_hist[RES_DUP], status_hist[RES_FOUND],
             status_hist[RES_NOTFOUND], status_hist[RES_REMOVED], status_hist[RES_FULL]);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/dhmt_pkg.sv
hdl/dhmt_step_mix.sv
hdl/dhmt_slot_store.sv
hdl/double_hash_map_with_tombstones_top.sv
dv/tb_double_hash_map_with_tombstones_top.sv
